/* src/lest_pkg.sv */
// Shared types, codes and helpers for the light event schedule table.
`timescale 1ns / 1ps

package lest_pkg;

  localparam int unsigned EventsDefault = 32;
  localparam int unsigned LightsDefault = 32;

  // input kinds
  localparam logic [2:0] KIND_ON     = 3'd0;
  localparam logic [2:0] KIND_OFF    = 3'd1;
  localparam logic [2:0] KIND_REMOVE = 3'd2;
  localparam logic [2:0] KIND_RANDOM = 3'd3;
  localparam logic [2:0] KIND_TICK   = 3'd4;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // day codes beyond single days
  localparam logic [3:0] DAY_EVERY   = 4'd7;
  localparam logic [3:0] DAY_WEEKDAY = 4'd8;
  localparam logic [3:0] DAY_WEEKEND = 4'd9;

  localparam int unsigned InWidth  = 40;
  localparam int unsigned OutWidth = 16;

  typedef struct packed {
    logic [7:0]  light;
    logic [3:0]  day;
    logic [11:0] minute;   // two's complement
    logic        turn_on;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  function automatic logic day_covers(input logic [3:0] day, input logic [2:0] today);
    logic hit;
    hit = 1'b0;
    if (day == DAY_EVERY) hit = 1'b1;
    if (day == {1'b0, today}) hit = 1'b1;
    if (day == DAY_WEEKEND && (today == 3'd0 || today == 3'd6)) hit = 1'b1;
    if (day == DAY_WEEKDAY && today >= 3'd1 && today <= 3'd5) hit = 1'b1;
    return hit;
  endfunction

endpackage

/* src/light_event_schedule_table_unit.sv */
// Top level: event table with a scan sequencer that reads one slot per cycle unless stalled.
//
//  channel  | dir | tdata / tuser / tlast
//  ---------+-----+---------------------------------------------------------
//  s_axis   | in  | tuser: kind; tdata: light_id, day_code, minute,
//           |     |   random_offset, today
//  m_axis   | out | tdata: is_command, status, cmd_light, cmd_on; tlast: last
//
// A full scan reads one table slot from the entry memory per cycle while the output
// does not stall it, checks each slot with the shared compare unit and then puts its
// final result in the output register; no new item is taken until the unit is idle.
// Schedule stops at the first free slot; an out-of-range light skips the scan.
// Unused kinds are dropped in ST_IDLE and give no result. A stalled output freezes
// the scan while a second command of a tick waits. Reset empties the table at once.
`timescale 1ns / 1ps

module light_event_schedule_table_unit
  import lest_pkg::*;
#(
  parameter int unsigned EVENTS = EventsDefault,
  parameter int unsigned LIGHTS = LightsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [7:0] light_id, [11:8] day_code, [22:12] minute, [29:23] random_offset,
  // [32:30] today, rest zero
  input  logic [InWidth-1:0]  s_axis_tdata_i,
  // [2:0] kind
  input  logic [2:0]          s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [0] is_command, [2:1] status, [10:3] cmd_light, [11] cmd_on, rest zero
  output logic [OutWidth-1:0] m_axis_tdata_o,
  output logic                m_axis_tlast_o
);

  localparam int unsigned AW = (EVENTS > 1) ? $clog2(EVENTS) : 1;
  localparam int unsigned IW = $clog2(EVENTS + 1);

  state_e state_q, state_d;

  // captured item
  logic [2:0]        kind_q;
  logic [7:0]        light_q;
  logic [3:0]        day_q;
  logic [10:0]       minute_q;
  logic signed [6:0] offset_q;
  logic [2:0]        today_q;
  logic [1:0]        status_q, status_d;

  // scan pipeline
  logic [IW-1:0]     idx_q, idx_d;
  logic [AW-1:0]     chk_q, chk_d;
  logic              pv_q, pv_d;
  logic              rd_en;
  entry_t            rd_q;

  logic [EVENTS-1:0] used_q, used_d;

  // pending tick command, emitted once the next one or the end is known
  logic              pend_v_q, pend_v_d;
  logic [7:0]        pend_light_q, pend_light_d;
  logic              pend_on_q, pend_on_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic              out_cmd_q, out_cmd_d;
  logic [1:0]        out_stat_q, out_stat_d;
  logic [7:0]        out_light_q, out_light_d;
  logic              out_on_q, out_on_d;
  logic              out_last_q, out_last_d;

  entry_t            mem_q [EVENTS];
  logic              we;
  logic [AW-1:0]     waddr;
  entry_t            wdata;

  logic              accept, out_free, used_chk, match, tick_hit, stall;
  logic [11:0]       key_minute;
  logic signed [12:0] sum;
  logic [11:0]       sat_minute;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign key_minute = {1'b0, minute_q};
  assign used_chk   = used_q[chk_q];
  assign match      = used_chk && rd_q.light == light_q && rd_q.day == day_q &&
                      rd_q.minute == key_minute;
  assign tick_hit   = used_chk && day_covers(rd_q.day, today_q) &&
                      rd_q.minute == key_minute;
  assign stall      = pv_q && kind_q == KIND_TICK && tick_hit && pend_v_q && !out_free;

  always_comb begin
    sum = $signed({rd_q.minute[11], rd_q.minute}) + 13'($signed(offset_q));
    if (sum > 13'sd2047) begin
      sat_minute = 12'h7FF;
    end else if (sum < -13'sd2048) begin
      sat_minute = 12'h800;
    end else begin
      sat_minute = sum[11:0];
    end
  end

  always_comb begin
    state_d      = state_q;
    status_d     = status_q;
    idx_d        = idx_q;
    chk_d        = chk_q;
    pv_d         = pv_q;
    rd_en        = 1'b0;
    used_d       = used_q;
    pend_v_d     = pend_v_q;
    pend_light_d = pend_light_q;
    pend_on_d    = pend_on_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_cmd_d    = out_cmd_q;
    out_stat_d   = out_stat_q;
    out_light_d  = out_light_q;
    out_on_d     = out_on_q;
    out_last_d   = out_last_q;
    we           = 1'b0;
    waddr        = chk_q;
    wdata        = rd_q;

    unique case (state_q)
      ST_IDLE: begin
        idx_d    = '0;
        pv_d     = 1'b0;
        pend_v_d = 1'b0;
        if (accept) begin
          case (s_axis_tuser_i) inside
            KIND_ON, KIND_OFF: begin
              if ({1'b0, s_axis_tdata_i[7:0]} >= 9'(LIGHTS)) begin
                status_d = STAT_RANGE;
                state_d  = ST_DONE;
              end else begin
                status_d = STAT_FULL;
                state_d  = ST_SCAN;
              end
            end
            KIND_REMOVE, KIND_RANDOM, KIND_TICK: begin
              status_d = STAT_OK;
              state_d  = ST_SCAN;
            end
            default: ;  // ignore unused kinds
          endcase
        end
      end

      ST_SCAN: begin
        if (!stall) begin
          // evaluate the slot fetched by the last issued read
          if (pv_q) begin
            case (kind_q) inside
              KIND_ON, KIND_OFF: begin
                if (!used_chk) begin
                  used_d[chk_q] = 1'b1;
                  we            = 1'b1;
                  wdata.light   = light_q;
                  wdata.day     = day_q;
                  wdata.minute  = key_minute;
                  wdata.turn_on = (kind_q == KIND_ON);
                  status_d      = STAT_OK;
                end
              end
              KIND_REMOVE: begin
                if (match) used_d[chk_q] = 1'b0;
              end
              KIND_RANDOM: begin
                if (match) begin
                  we           = 1'b1;
                  wdata.minute = sat_minute;
                end
              end
              default: begin
                if (tick_hit) begin
                  if (pend_v_q) begin
                    out_valid_d = 1'b1;
                    out_cmd_d   = 1'b1;
                    out_stat_d  = STAT_OK;
                    out_light_d = pend_light_q;
                    out_on_d    = pend_on_q;
                    out_last_d  = 1'b0;
                  end
                  pend_v_d     = 1'b1;
                  pend_light_d = rd_q.light;
                  pend_on_d    = rd_q.turn_on;
                end
              end
            endcase
          end
          // issue the next read, or close the scan
          if ((kind_q == KIND_ON || kind_q == KIND_OFF) && pv_q && !used_chk) begin
            pv_d    = 1'b0;
            state_d = ST_DONE;
          end else if (idx_q < IW'(EVENTS)) begin
            rd_en = 1'b1;
            pv_d  = 1'b1;
            chk_d = idx_q[AW-1:0];
            idx_d = idx_q + 1'b1;
          end else begin
            pv_d = 1'b0;
            if (!pv_q) state_d = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (kind_q == KIND_TICK) begin
          if (!pend_v_q) begin
            state_d = ST_IDLE;
          end else if (out_free) begin
            out_valid_d = 1'b1;
            out_cmd_d   = 1'b1;
            out_stat_d  = STAT_OK;
            out_light_d = pend_light_q;
            out_on_d    = pend_on_q;
            out_last_d  = 1'b1;
            pend_v_d    = 1'b0;
            state_d     = ST_IDLE;
          end
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_cmd_d   = 1'b0;
          out_stat_d  = status_q;
          out_light_d = '0;
          out_on_d    = 1'b0;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      status_q    <= STAT_OK;
      idx_q       <= '0;
      chk_q       <= '0;
      pv_q        <= 1'b0;
      used_q      <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      idx_q       <= idx_d;
      chk_q       <= chk_d;
      pv_q        <= pv_d;
      used_q      <= used_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= s_axis_tuser_i;
      light_q  <= s_axis_tdata_i[7:0];
      day_q    <= s_axis_tdata_i[11:8];
      minute_q <= s_axis_tdata_i[22:12];
      offset_q <= $signed(s_axis_tdata_i[29:23]);
      today_q  <= s_axis_tdata_i[32:30];
    end
    pend_light_q <= pend_light_d;
    pend_on_q    <= pend_on_d;
    out_cmd_q    <= out_cmd_d;
    out_stat_q   <= out_stat_d;
    out_light_q  <= out_light_d;
    out_on_q     <= out_on_d;
    out_last_q   <= out_last_d;
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (rd_en) rd_q <= mem_q[idx_q[AW-1:0]];
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {{(OutWidth - 12){1'b0}}, out_on_q, out_light_q,
                            out_stat_q, out_cmd_q};

`ifndef ASSERT_OFF
  a_idle_no_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !pv_q && !pend_v_q)
    else $error("scan pipeline busy while idle");

  a_cmd_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_cmd_q |-> out_stat_q == STAT_OK)
    else $error("light command carries a nonzero status");

  a_range_skips_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (s_axis_tuser_i == KIND_ON || s_axis_tuser_i == KIND_OFF) &&
    {1'b0, s_axis_tdata_i[7:0]} >= 9'(LIGHTS) |=> state_q == ST_DONE)
    else $error("out-of-range light entered the scan");

  a_scan_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> {1'b0, chk_q} < (AW + 1)'(EVENTS))
    else $error("scan checks a slot beyond the table");

  a_stall_holds_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN && stall |=> $stable(idx_q) && $stable(chk_q))
    else $error("scan advanced while a command was blocked");
`endif

endmodule
